// ===== design/hcbp_pkg.sv =====
// Shared types and constants for the code bit packer.
// Depends on nothing; every other design file but hcbp_ram imports it.
package hcbp_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_BITS = 32;
  localparam int LEN_W     = 6;
  localparam int SYM_W     = 8;
  localparam int KIND_W    = 2;
  localparam int MAX_BYTES = 4;
  localparam int NUM_W     = 3;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int IN_DATA_W = 48;
  localparam int STREAM_W  = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  // One item after the table lookup, as handed to the packer.
  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic                 load_err;
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] word;
  } stage_t;

endpackage

// ===== design/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hcbp_lookup.sv =====
// Input stage of the code bit packer: word acceptance, code table and its valid bits.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_lookup #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [hcbp_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  logic [hcbp_pkg::KIND_W-1:0]    s_tuser_i,
  input  logic                           advance_i,
  output hcbp_pkg::stage_t               stage_o
);
  import hcbp_pkg::*;

  localparam int AddrW    = $clog2(SYMBOL_COUNT);
  localparam int LenLimit = (MAX_CODE_LEN > WORD_BITS) ? WORD_BITS : MAX_CODE_LEN;
  localparam int EntryW   = LEN_W + WORD_BITS;

  logic [SYM_W-1:0]     sym;
  logic [WORD_BITS-1:0] word;
  logic [LEN_W-1:0]     len;
  kind_e                kind;
  logic                 in_table;
  logic                 len_ok;
  logic                 accept;
  logic                 we;
  logic                 re;
  logic [AddrW-1:0]     addr;
  logic [EntryW-1:0]    rdata;

  logic [SYMBOL_COUNT-1:0] valid_q;
  logic                    a_valid_q;
  kind_e                   a_kind_q;
  logic                    a_err_q;
  logic                    a_hit_q;

  logic [LEN_W-1:0]     len_eff;
  logic [WORD_BITS-1:0] word_eff;

  assign sym      = s_tdata_i[SYM_W-1:0];
  assign word     = s_tdata_i[SYM_W+WORD_BITS-1:SYM_W];
  assign len      = s_tdata_i[SYM_W+WORD_BITS+LEN_W-1:SYM_W+WORD_BITS];
  assign kind     = kind_e'(s_tuser_i);
  assign in_table = ({1'b0, sym} < 9'(SYMBOL_COUNT));
  assign len_ok   = (len <= LEN_W'(LenLimit));
  assign addr     = sym[AddrW-1:0];

  assign s_tready_o = !a_valid_q || advance_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign we         = accept && (kind == KIND_LOAD) && in_table && len_ok;
  assign re         = accept && (kind == KIND_ENCODE);

  hcbp_ram #(
    .WIDTH(EntryW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i({len, word}),
    .re_i   (re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[addr] <= 1'b1;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (advance_i) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_kind_q <= kind;
      a_err_q  <= !(in_table && len_ok);
      a_hit_q  <= in_table && valid_q[addr];
    end
  end

  // Entries never loaded read as length zero with no code bits.
  assign len_eff  = a_hit_q ? rdata[EntryW-1:WORD_BITS] : '0;
  assign word_eff = (len_eff != '0) ? rdata[WORD_BITS-1:0] : '0;

  always_comb begin
    stage_o.valid    = a_valid_q;
    stage_o.kind     = a_kind_q;
    stage_o.load_err = a_err_q;
    stage_o.len      = len_eff;
    stage_o.word     = word_eff;
  end

endmodule

// ===== design/hcbp_packer.sv =====
// Bit accumulator and output byte buffer of the code bit packer.
// Depends on hcbp_pkg.
module hcbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcbp_pkg::stage_t            stage_i,
  output logic                        advance_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [hcbp_pkg::BYTE_W-1:0] m_tdata_o,
  output logic                        m_tuser_o,
  output logic                        m_tlast_o
);
  import hcbp_pkg::*;

  // Pending bits are kept left aligned: the earliest waiting bit sits in the top bit.
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  pcnt_q, pcnt_d;

  logic                   b_valid_q, b_valid_d;
  logic [BYTE_W-1:0]      b_byte_q [MAX_BYTES];
  logic [NUM_W-1:0]       b_num_q;
  logic [1:0]             b_idx_q, b_idx_d;
  logic                   b_err_q;

  logic [WORD_BITS-1:0]   word_al;
  logic [STREAM_W-1:0]    stream;
  logic [LEN_W-1:0]       total;
  logic [NUM_W-1:0]       num;
  logic [BYTE_W-1:0]      bytes [MAX_BYTES];
  logic                   err;
  logic                   b_free;
  logic                   m_accept;
  logic                   load_b;

  assign word_al = stage_i.word << (LEN_W'(WORD_BITS) - stage_i.len);
  assign stream  = {pend_q, {(STREAM_W-PEND_W){1'b0}}}
                 | ({word_al, {BYTE_W{1'b0}}} >> pcnt_q);
  assign total   = LEN_W'(pcnt_q) + stage_i.len;

  always_comb begin
    num    = '0;
    err    = 1'b0;
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    for (int k = 0; k < MAX_BYTES; k++) begin
      bytes[k] = stream[STREAM_W-1-BYTE_W*k -: BYTE_W];
    end
    case (stage_i.kind)
      KIND_LOAD: begin
        num      = NUM_W'(1);
        err      = stage_i.load_err;
        bytes[0] = '0;
      end
      KIND_ENCODE: begin
        num    = total[LEN_W-1:3];
        pcnt_d = total[2:0];
        case (num)
          3'd0:    pend_d = stream[39:33];
          3'd1:    pend_d = stream[31:25];
          3'd2:    pend_d = stream[23:17];
          3'd3:    pend_d = stream[15:9];
          default: pend_d = stream[7:1];
        endcase
      end
      KIND_FLUSH: begin
        num      = (pcnt_q != '0) ? NUM_W'(1) : '0;
        bytes[0] = {pend_q, 1'b0};
        pend_d   = '0;
        pcnt_d   = '0;
      end
      default: begin
        num = '0;
      end
    endcase
  end

  assign m_tvalid_o = b_valid_q;
  assign m_tdata_o  = b_byte_q[b_idx_q];
  assign m_tuser_o  = b_err_q;
  assign m_tlast_o  = ((NUM_W'(b_idx_q) + NUM_W'(1)) == b_num_q);
  assign m_accept   = m_tvalid_o && m_tready_i;

  assign b_free    = !b_valid_q || (m_tready_i && m_tlast_o);
  assign advance_o = stage_i.valid && ((num == '0) || b_free);
  assign load_b    = advance_o && (num != '0);

  always_comb begin
    b_valid_d = b_valid_q;
    b_idx_d   = b_idx_q;
    if (m_accept) begin
      if (m_tlast_o) begin
        b_valid_d = 1'b0;
      end else begin
        b_idx_d = b_idx_q + 2'd1;
      end
    end
    if (load_b) begin
      b_valid_d = 1'b1;
      b_idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      pcnt_q    <= '0;
      b_valid_q <= 1'b0;
      b_idx_q   <= '0;
    end else begin
      if (advance_o) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
      b_valid_q <= b_valid_d;
      b_idx_q   <= b_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_byte_q <= bytes;
      b_num_q  <= num;
      b_err_q  <= err;
    end
  end

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Top level of the code bit packer: table lookup stage followed by the bit packer.
// Depends on hcbp_pkg, hcbp_lookup, hcbp_packer and hcbp_ram.
//
// Usage. Words arrive on the s_axis channel; tuser carries the kind (load a table
// entry, encode a symbol, flush the partial byte) and tdata carries symbol, code
// word and code length. Result words leave on the m_axis channel, one byte each,
// with tuser flagging a refused load and tlast marking the final result of an input.
// Loads always answer with one word; an encode answers with zero to four bytes;
// a flush answers with one byte only if bits are waiting.
// Result path: the first result of an input word passes the registered table read
// and then the result register; a stall at the output can hold it in between.
// Throughput: one input word per cycle while each gives at most one result and the
// receiver is ready; an encode completing more than one byte holds the output until
// all are taken, so the output byte rate of one per cycle bounds the sustained rate.
// The single read port of the code table serves one lookup per cycle.
// Reset clears the waiting bits, the output buffer and the valid bit of every
// table entry, so all entries read as length zero until loaded; no clearing pass.
// When the receiver stalls, the current result word holds steady, the lookup
// stage keeps one further word, and s_axis_tready_o falls until space returns.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata, lowest bit up: symbol [7:0], code_word [39:8], code_length [45:40], zeros.
  input  logic [hcbp_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: kind [1:0].
  input  logic [hcbp_pkg::KIND_W-1:0]    s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: out_byte [7:0].
  output logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata_o,
  // tuser: load_error [0].
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import hcbp_pkg::*;

  stage_t stage;
  logic   advance;

  // Lookup stage: accepts words, writes or reads the code table.
  hcbp_lookup #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // Packing stage: merges the code with the waiting bits and buffers the bytes.
  hcbp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o),
    .m_tlast_o (m_axis_tlast_o)
  );

endmodule

// ===== design/hcbp_checker.sv =====
// Port-level checks for the code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer.
module hcbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata_o,
  input logic                           m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import hcbp_pkg::*;

  // A refused load answers with a single zero byte.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("load error word is not a lone zero byte");

  // The input only stalls behind a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // A taken byte that is not the last of its input is followed by the next one.
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("result burst broken off before its last byte");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result word changed");

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);

// ===== sim/huffman_code_bit_packer_checker.sv =====
// Checker for the code bit packer: watches both stream channels, predicts the result words.
// It compares each result word with the oldest prediction. Depends on hcbp_pkg.
module huffman_code_bit_packer_checker #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [hcbp_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [hcbp_pkg::KIND_W-1:0]    s_axis_tuser_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata_i,
  input  logic                           m_axis_tuser_i,
  input  logic                           m_axis_tlast_i,
  output int                             errors_o,
  output int                             awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              load_err;
    logic              last;
  } out_word_t;

  out_word_t            awaited_words[$];
  logic [WORD_BITS-1:0] code_bits_mem[256];
  logic [LEN_W-1:0]     code_len_mem[256];
  logic [PEND_W-1:0]    held_bits;
  logic [CNT_W-1:0]     held_count;
  int                   error_count;
  out_word_t            got;

  localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

  initial begin
    for (int i = 0; i < 256; i++) begin
      code_bits_mem[i] = '0;
      code_len_mem[i]  = '0;
    end
    held_bits   = '0;
    held_count  = '0;
    error_count = 0;
    errors_o    = 0;
    awaited_o   = 0;
  end

  // Applies one accepted input word to the local copy of the table and the bit
  // accumulator, and queues the result words it must produce.
  task automatic predict_words(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                               input logic [WORD_BITS-1:0] code, input logic [LEN_W-1:0] clen);
    out_word_t                 w;
    logic [WORD_BITS-1:0]      mask;
    logic [PEND_W+WORD_BITS-1:0] acc;
    logic [BYTE_W-1:0]         burst[MAX_BYTES];
    int                        n;
    int                        total;
    int                        nbytes;
    int                        sh;
    case (kind)
      KIND_LOAD: begin
        w.data     = '0;
        w.last     = 1'b1;
        w.load_err = (int'(sym) >= SYMBOL_COUNT) || (int'(clen) > LEN_LIMIT);
        if (!w.load_err) begin
          code_bits_mem[sym] = code;
          code_len_mem[sym]  = clen;
        end
        awaited_words.push_back(w);
      end
      KIND_ENCODE: begin
        if (int'(sym) < SYMBOL_COUNT && code_len_mem[sym] != 0) begin
          n      = code_len_mem[sym];
          mask   = (n >= WORD_BITS) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
          acc    = ({{WORD_BITS{1'b0}}, held_bits} << n) |
                   {{PEND_W{1'b0}}, code_bits_mem[sym] & mask};
          total  = int'(held_count) + n;
          nbytes = 0;
          while (total >= BYTE_W && nbytes < MAX_BYTES) begin
            burst[nbytes] = 8'(acc >> (total - BYTE_W));
            total  -= BYTE_W;
            nbytes++;
          end
          for (int i = 0; i < nbytes; i++) begin
            w.data     = burst[i];
            w.load_err = 1'b0;
            w.last     = (i == nbytes - 1);
            awaited_words.push_back(w);
          end
          held_count = CNT_W'(total);
          held_bits  = PEND_W'(acc & ((39'd1 << total) - 39'd1));
        end
      end
      KIND_FLUSH: begin
        if (held_count != 0) begin
          sh         = BYTE_W - int'(held_count);
          w.data     = 8'({1'b0, held_bits} << sh);
          w.load_err = 1'b0;
          w.last     = 1'b1;
          awaited_words.push_back(w);
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Result side first, so that a word arriving with nothing awaited is not
      // hidden by a prediction made at the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: out_byte %02h load_error %0b last %0b",
                 m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
          error_count++;
        end else begin
          got = awaited_words.pop_front();
          if (got.data !== m_axis_tdata_i) begin
            $error("out_byte: expected %02h, actual %02h", got.data, m_axis_tdata_i);
            error_count++;
          end
          if (got.load_err !== m_axis_tuser_i) begin
            $error("load_error: expected %0b, actual %0b", got.load_err, m_axis_tuser_i);
            error_count++;
          end
          if (got.last !== m_axis_tlast_i) begin
            $error("last: expected %0b, actual %0b", got.last, m_axis_tlast_i);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_words(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[39:8],
                      s_axis_tdata_i[45:40]);
      end
    end
    errors_o  <= error_count;
    awaited_o <= awaited_words.size();
  end

endmodule

// ===== sim/huffman_code_bit_packer_test.sv =====
// Testbench top for the code bit packer: clock, reset, stimulus, receiver and verdict.
// Depends on hcbp_pkg, the design and huffman_code_bit_packer_checker.
module huffman_code_bit_packer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  localparam int MAX_CODE_LEN    = 32;
  localparam int SYMBOL_COUNT    = 256;
  // Kind 3 has no meaning in the block; it must be swallowed without a result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int PRESSURE_ITEMS  = 24;
  localparam int POOL_SIZE       = 16;
  // The receiver's long hold-off, and the watchdog limit on cycles without any
  // accepted word. The limit sits well above the hold-off plus the worst random
  // stalls, so only a block that has really stopped trips it.
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 3000;
  // Wait after the results drain, long enough to catch a late stray word.
  localparam int TAIL_CYCLES     = 12;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0]    s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  int check_errors;
  int words_awaited;
  int send_idle_pct;
  int recv_stall_pct;
  int holds_asked;
  int holds_done;
  int quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  huffman_code_bit_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  huffman_code_bit_packer_checker #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .m_axis_tlast_i (m_axis_tlast),
    .errors_o       (check_errors),
    .awaited_o      (words_awaited)
  );

  // Offers one word and returns at the edge at which it is accepted. Random idle
  // cycles go before the word, so valid only falls between words, never while
  // one is on offer.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [WORD_BITS-1:0] code, input logic [LEN_W-1:0] clen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, clen, code, sym};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Code lengths lean towards short codes, so bytes complete at varied bit
  // offsets, with some full 32-bit codes, some refused lengths and a few zero
  // lengths that empty an entry again.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 70) return LEN_W'($urandom_range(12, 1));
    if (r < 90) return LEN_W'($urandom_range(32, 13));
    return LEN_W'($urandom_range(63, 33));
  endfunction

  // Most symbols come from a small pool, so that encodes mostly hit loaded
  // entries and loads overwrite live ones; the rest range over the whole table.
  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(99) < 85) return SYM_W'($urandom_range(POOL_SIZE - 1));
    return SYM_W'($urandom());
  endfunction

  // One phase of random traffic with the given idle and stall percentages.
  // Ignored words of the unused kind do not count towards the phase length.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int done;
    int r;
    done           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 22) begin
        send_word(KIND_LOAD, pick_symbol(), $urandom(), pick_length());
        done++;
      end else if (r < 84) begin
        send_word(KIND_ENCODE, pick_symbol(), $urandom(), LEN_W'($urandom()));
        done++;
      end else if (r < 95) begin
        send_word(KIND_FLUSH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
        done++;
      end else begin
        send_word(KIND_UNUSED, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
      end
    end
  endtask

  // Receiver: ready follows the stall percentage of the current phase, except
  // when the stimulus asks for a long hold-off, which is counted out here.
  initial begin
    m_axis_tready = 1'b0;
    holds_done    = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_done + 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a run of cycles with no word accepted on either side means the
  // block has hung, or a result it owes is never coming.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_asked    = 0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Before anything is loaded, an encode finds an empty entry
    // and a flush finds no waiting bits; neither answers. The unused kind
    // goes with every field at its all-ones value.
    send_word(KIND_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(KIND_FLUSH, 8'd255, 32'h0, 6'd0);
    send_word(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Loads: a zero length, the longest legal code, lengths just and far over
    // the limit (refused), and a one-bit code whose upper word bits must be
    // ignored.
    send_word(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(KIND_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_word(KIND_LOAD, 8'd1, 32'h1234_5678, 6'd33);
    send_word(KIND_LOAD, 8'd2, 32'h0, 6'd63);
    send_word(KIND_LOAD, 8'd3, 32'hFFFF_FFFE, 6'd1);
    send_word(KIND_LOAD, 8'd4, 32'hFFFF_FF55, 6'd7);
    send_word(KIND_LOAD, 8'd5, 32'h0000_00A5, 6'd8);
    send_word(KIND_LOAD, 8'd6, $urandom(), 6'd31);
    // A 32-bit code on an empty accumulator gives four bytes; after seven
    // waiting bits it reaches thirty-nine bits and again gives four bytes.
    send_word(KIND_ENCODE, 8'd255, 32'h0, 6'd0);
    send_word(KIND_ENCODE, 8'd4, 32'h0, 6'd0);
    send_word(KIND_ENCODE, 8'd255, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    // A single waiting bit is flushed with seven zero bits of padding.
    send_word(KIND_ENCODE, 8'd3, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    // An exact byte, then an entry loaded with length zero, which adds nothing.
    send_word(KIND_ENCODE, 8'd5, 32'h0, 6'd0);
    send_word(KIND_ENCODE, 8'd0, 32'h0, 6'd0);
    send_word(KIND_ENCODE, 8'd6, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);

    // Fill the symbol pool with legal codes so the random traffic encodes
    // real bits from the outset.
    for (int i = 0; i < POOL_SIZE; i++) begin
      send_word(KIND_LOAD, SYM_W'(i), $urandom(), LEN_W'($urandom_range(16, 1)));
    end

    // Random traffic under each idling pattern.
    run_phase(0, 0, ITEMS_PER_PHASE);
    run_phase(48, 0, ITEMS_PER_PHASE);
    run_phase(0, 48, ITEMS_PER_PHASE);
    run_phase(36, 36, ITEMS_PER_PHASE);

    // Back pressure: the receiver holds off for a long stretch while full
    // 32-bit codes keep arriving, so the output and lookup stages fill and
    // input ready has to fall.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(KIND_LOAD, 8'd255, $urandom(), 6'd32);
    holds_asked <= holds_asked + 1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_word(KIND_ENCODE, 8'd255, $urandom(), LEN_W'($urandom()));
    end
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    s_axis_tvalid <= 1'b0;

    // The awaited count is registered in the checker, so give it one edge to
    // take in the last word before waiting for the results to drain.
    @(posedge clk_i);
    while (words_awaited != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (check_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
